@@ rtl/ppt_pkg.sv @@
`default_nettype none
package ppt_pkg;

    localparam int ELEM_W    = 32;
    localparam int MAT_N     = 16;
    localparam int ROWS      = 3;
    localparam int TERMS     = 4;
    localparam int PROD_W    = 64;
    localparam int SUM_W     = 66;
    localparam int MAG_W     = 64;
    localparam int FRAC_W    = 16;
    localparam int NLO_W     = 17;
    localparam int Q_W       = 33;
    localparam int DIV_STEPS = 33;
    localparam int CFG_W     = 64;
    localparam int CFG_WORDS = 8;
    localparam int CFG_IDX_W = 3;

    localparam logic [ELEM_W-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [ELEM_W-1:0] SAT_NEG = 32'h8000_0000;

    // identity matrix, two elements per word
    localparam logic [CFG_W-1:0] MAT_RESET [CFG_WORDS] = '{
        64'h0000_0000_0001_0000, 64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000, 64'h0000_0000_0000_0000,
        64'h0000_0000_0000_0000, 64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000, 64'h0001_0000_0000_0000
    };

    typedef logic [MAT_N-1:0][ELEM_W-1:0] matrix_t;

    // classified request handed from the front to the divider
    typedef struct packed {
        logic [ROWS-1:0][MAG_W-1:0] nmag;
        logic [ROWS-1:0]            nneg;
        logic [ROWS-1:0]            rneg;
        logic [ROWS-1:0]            big;
        logic [MAG_W-1:0]           dmag;
        logic                       wz;
    } entry_t;

    typedef struct packed {
        logic [ROWS-1:0] nneg;
        logic [ROWS-1:0] rneg;
        logic [ROWS-1:0] big;
        logic            wz;
    } flags_t;

endpackage
`default_nettype wire

@@ rtl/ppt_point_if.sv @@
`default_nettype none
interface ppt_point_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;

    modport source (output valid, output in_x, output in_y, output in_z, input ready);
    modport sink   (input valid, input in_x, input in_y, input in_z, output ready);
endinterface
`default_nettype wire

@@ rtl/ppt_result_if.sv @@
`default_nettype none
interface ppt_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               w_is_zero;
    logic               overflowed;

    modport source (output valid, output out_x, output out_y, output out_z,
                    output w_is_zero, output overflowed, input ready);
    modport sink   (input valid, input out_x, input out_y, input out_z,
                    input w_is_zero, input overflowed, output ready);
endinterface
`default_nettype wire

@@ rtl/point_transform_perspective.sv @@
// path: front stages a to d, the queue, 34 divider stages with the load, output register
// throughput: one point per cycle unless result.ready or the credit stalls; the quotient
//   divider is fully pipelined, one quotient bit per stage, and the front and queue
//   together hold QUEUE_DEPTH points
// reset: matrix returns to identity, all pipelines and the queue empty
`default_nettype none
module point_transform_perspective #(
    parameter int QUEUE_DEPTH = 8
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [ppt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ppt_pkg::CFG_W-1:0]     cfg_data,
    ppt_point_if.sink                          point,
    ppt_result_if.source                       result
);
    import ppt_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [CFG_W-1:0] word_reg [CFG_WORDS];
    matrix_t          matrix;
    logic [CNT_W-1:0] credit_reg, credit_next;
    logic             space, accept, push, pop, not_empty;
    entry_t           entry, rdata;

    // matrix words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < CFG_WORDS; k++)
            begin
                word_reg[k] <= MAT_RESET[k];
            end
        end
        else if (cfg_we)
        begin
            word_reg[cfg_index] <= cfg_data;
        end
    end

    always_comb
    begin
        for (int k = 0; k < CFG_WORDS; k++)
        begin
            matrix[2*k]   = word_reg[k][ELEM_W-1:0];
            matrix[2*k+1] = word_reg[k][CFG_W-1:ELEM_W];
        end
    end

    // points in the front or the queue, bounded by the queue depth
    assign accept      = point.valid & point.ready;
    assign space       = credit_reg < CNT_W'(QUEUE_DEPTH);
    assign credit_next = credit_reg + CNT_W'(accept) - CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg <= '0;
        end
        else
        begin
            credit_reg <= credit_next;
        end
    end

    ppt_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .matrix (matrix),
        .space  (space),
        .point  (point),
        .push   (push),
        .entry  (entry)
    );

    ppt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wdata     (entry),
        .pop       (pop),
        .rdata     (rdata),
        .not_empty (not_empty)
    );

    ppt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .not_empty (not_empty),
        .rdata     (rdata),
        .pop       (pop),
        .result    (result)
    );

endmodule
`default_nettype wire

@@ rtl/ppt_front.sv @@
`default_nettype none
module ppt_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire ppt_pkg::matrix_t matrix,
    input  wire logic             space,
    ppt_point_if.sink             point,
    output logic                  push,
    output ppt_pkg::entry_t       entry
);
    import ppt_pkg::*;

    logic                            accept;
    logic                            va_reg, vb_reg, vc_reg, push_reg;
    logic signed [PROD_W-1:0]        prod_reg [TERMS][ROWS];
    logic signed [ELEM_W-1:0]        trans_reg [TERMS];
    logic signed [SUM_W-1:0]         sum_reg [TERMS];
    logic signed [SUM_W-1:0]         sum_next [TERMS];
    logic [ROWS-1:0][MAG_W-1:0]      nmag_reg;
    logic [ROWS-1:0]                 nneg_reg;
    logic [MAG_W-1:0]                dmag_reg;
    logic                            dneg_reg;
    logic                            wz_reg;
    logic [TERMS-1:0][MAG_W-1:0]     mag_next;
    logic [TERMS-1:0]                neg_next;
    entry_t                          entry_reg, entry_next;
    logic signed [ELEM_W-1:0]        coord [ROWS];
    logic [SUM_W-1:0]                negsum [TERMS];

    assign point.ready = space;
    assign accept      = point.valid & space;
    assign coord[0]    = point.in_x;
    assign coord[1]    = point.in_y;
    assign coord[2]    = point.in_z;

    // valid pipe, the front never stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg   <= 1'b0;
            vb_reg   <= 1'b0;
            vc_reg   <= 1'b0;
            push_reg <= 1'b0;
        end
        else
        begin
            va_reg   <= accept;
            vb_reg   <= va_reg;
            vc_reg   <= vb_reg;
            push_reg <= vc_reg;
        end
    end

    // stage a: twelve products and the translation column
    always_ff @(posedge clk)
    begin
        for (int r = 0; r < TERMS; r++)
        begin
            for (int c = 0; c < ROWS; c++)
            begin
                prod_reg[r][c] <= $signed(matrix[4*c+r]) * coord[c];
            end
            trans_reg[r] <= $signed(matrix[12+r]);
        end
    end

    // stage b: exact row sums
    always_comb
    begin
        for (int r = 0; r < TERMS; r++)
        begin
            sum_next[r] = SUM_W'(prod_reg[r][0]) + SUM_W'(prod_reg[r][1])
                        + SUM_W'(prod_reg[r][2]) + (SUM_W'(trans_reg[r]) <<< FRAC_W);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int r = 0; r < TERMS; r++)
        begin
            sum_reg[r] <= sum_next[r];
        end
    end

    // stage c: sign and magnitude
    always_comb
    begin
        for (int r = 0; r < TERMS; r++)
        begin
            negsum[r]   = -sum_reg[r];
            neg_next[r] = sum_reg[r][SUM_W-1];
            mag_next[r] = neg_next[r] ? negsum[r][MAG_W-1:0] : sum_reg[r][MAG_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int r = 0; r < ROWS; r++)
        begin
            nmag_reg[r] <= mag_next[r];
            nneg_reg[r] <= neg_next[r];
        end
        dmag_reg <= mag_next[ROWS];
        dneg_reg <= neg_next[ROWS];
        wz_reg   <= (sum_reg[ROWS] == '0);
    end

    // stage d: quotient range check and result sign
    always_comb
    begin
        entry_next.nmag = nmag_reg;
        entry_next.nneg = nneg_reg;
        entry_next.dmag = dmag_reg;
        entry_next.wz   = wz_reg;
        for (int r = 0; r < ROWS; r++)
        begin
            entry_next.big[r]  = {{NLO_W{1'b0}}, nmag_reg[r]} >= {dmag_reg, {NLO_W{1'b0}}};
            entry_next.rneg[r] = (nneg_reg[r] != dneg_reg) && (nmag_reg[r] != '0);
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign push  = push_reg;
    assign entry = entry_reg;

endmodule
`default_nettype wire

@@ rtl/ppt_queue.sv @@
`default_nettype none
module ppt_queue #(
    parameter int DEPTH = 8
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire ppt_pkg::entry_t wdata,
    input  wire logic            pop,
    output ppt_pkg::entry_t      rdata,
    output logic                 not_empty
);
    import ppt_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t           mem [DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // pointer wrap
    always_comb
    begin
        wr_next  = (wr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        rd_next  = (rd_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        cnt_next = cnt_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_next;
            end
            if (pop)
            begin
                rd_reg <= rd_next;
            end
            cnt_reg <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= wdata;
        end
    end

    assign rdata     = mem[rd_reg];
    assign not_empty = (cnt_reg != '0);

endmodule
`default_nettype wire

@@ rtl/ppt_back.sv @@
`default_nettype none
module ppt_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            not_empty,
    input  wire ppt_pkg::entry_t rdata,
    output logic                 pop,
    ppt_result_if.source         result
);
    import ppt_pkg::*;

    logic                   back_en;
    logic [DIV_STEPS:0]     v_reg;
    logic [MAG_W-1:0]       r_reg   [DIV_STEPS+1][ROWS];
    logic [NLO_W-1:0]       nlo_reg [DIV_STEPS+1][ROWS];
    logic [Q_W-1:0]         q_reg   [DIV_STEPS+1][ROWS];
    logic [MAG_W-1:0]       d_reg   [DIV_STEPS+1];
    flags_t                 f_reg   [DIV_STEPS+1];
    logic [MAG_W-1:0]       r_next  [DIV_STEPS][ROWS];
    logic [Q_W-1:0]         q_next  [DIV_STEPS][ROWS];
    logic [MAG_W:0]         trial   [DIV_STEPS][ROWS];
    logic [MAG_W:0]         diff    [DIV_STEPS][ROWS];
    logic                   ge      [DIV_STEPS][ROWS];
    logic [ELEM_W-1:0]      val_next [ROWS];
    logic [ROWS-1:0]        ovf_next;
    logic [Q_W-1:0]         qf;
    logic [ELEM_W-1:0]      val_reg [ROWS];
    logic                   res_valid_reg, wz_reg, ovf_reg;

    assign back_en = !res_valid_reg || result.ready;
    assign pop     = back_en && not_empty;

    // one restoring step per stage, three lanes share the divisor
    always_comb
    begin
        for (int s = 0; s < DIV_STEPS; s++)
        begin
            for (int l = 0; l < ROWS; l++)
            begin
                trial[s][l]  = {r_reg[s][l], nlo_reg[s][l][NLO_W-1]};
                diff[s][l]   = trial[s][l] - {1'b0, d_reg[s]};
                ge[s][l]     = trial[s][l] >= {1'b0, d_reg[s]};
                r_next[s][l] = ge[s][l] ? diff[s][l][MAG_W-1:0] : trial[s][l][MAG_W-1:0];
                q_next[s][l] = {q_reg[s][l][Q_W-2:0], ge[s][l]};
            end
        end
    end

    // divider valid pipe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (back_en)
        begin
            v_reg <= {v_reg[DIV_STEPS-1:0], pop};
        end
    end

    // divider payload
    always_ff @(posedge clk)
    begin
        if (back_en)
        begin
            for (int l = 0; l < ROWS; l++)
            begin
                r_reg[0][l]   <= {{NLO_W{1'b0}}, rdata.nmag[l][MAG_W-1:NLO_W]};
                nlo_reg[0][l] <= rdata.nmag[l][NLO_W-1:0];
                q_reg[0][l]   <= '0;
            end
            d_reg[0]      <= rdata.dmag;
            f_reg[0].nneg <= rdata.nneg;
            f_reg[0].rneg <= rdata.rneg;
            f_reg[0].big  <= rdata.big;
            f_reg[0].wz   <= rdata.wz;
            for (int s = 0; s < DIV_STEPS; s++)
            begin
                for (int l = 0; l < ROWS; l++)
                begin
                    r_reg[s+1][l]   <= r_next[s][l];
                    nlo_reg[s+1][l] <= {nlo_reg[s][l][NLO_W-2:0], 1'b0};
                    q_reg[s+1][l]   <= q_next[s][l];
                end
                d_reg[s+1] <= d_reg[s];
                f_reg[s+1] <= f_reg[s];
            end
        end
    end

    // sign, saturation and zero divisor
    always_comb
    begin
        qf = '0;
        for (int l = 0; l < ROWS; l++)
        begin
            qf = q_reg[DIV_STEPS][l];
            ovf_next[l] = 1'b0;
            if (f_reg[DIV_STEPS].wz)
            begin
                val_next[l] = f_reg[DIV_STEPS].nneg[l] ? SAT_NEG : SAT_POS;
            end
            else if (f_reg[DIV_STEPS].rneg[l])
            begin
                if (f_reg[DIV_STEPS].big[l] || qf > {1'b0, SAT_NEG})
                begin
                    val_next[l] = SAT_NEG;
                    ovf_next[l] = 1'b1;
                end
                else
                begin
                    val_next[l] = ELEM_W'(0) - qf[ELEM_W-1:0];
                end
            end
            else
            begin
                if (f_reg[DIV_STEPS].big[l] || qf > {1'b0, SAT_POS})
                begin
                    val_next[l] = SAT_POS;
                    ovf_next[l] = 1'b1;
                end
                else
                begin
                    val_next[l] = qf[ELEM_W-1:0];
                end
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (back_en)
        begin
            res_valid_reg <= v_reg[DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (back_en)
        begin
            for (int l = 0; l < ROWS; l++)
            begin
                val_reg[l] <= val_next[l];
            end
            wz_reg  <= f_reg[DIV_STEPS].wz;
            ovf_reg <= |ovf_next;
        end
    end

    assign result.valid      = res_valid_reg;
    assign result.out_x      = $signed(val_reg[0]);
    assign result.out_y      = $signed(val_reg[1]);
    assign result.out_z      = $signed(val_reg[2]);
    assign result.w_is_zero  = wz_reg;
    assign result.overflowed = ovf_reg;

endmodule
`default_nettype wire
